@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the serial-text to CAN frame parser.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Concurrent assertion, clocked on clk, disabled while rst_n is low
`define AHCAN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge
`define AHCAN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `AHCAN_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define AHCAN_ASSERT(lbl, clk, rst_n, prop, msg)
`define AHCAN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/ahcan_pkg.sv @@
// Package for the serial-text to CAN frame parser: request and frame types,
// character constants and the hex digit decoder. Depends on nothing.
package ahcan_pkg;

  localparam int unsigned CHUNK_DEPTH_DEF = 25;  // characters kept per chunk
  localparam int unsigned MAX_PAYLOAD     = 8;   // largest data length accepted
  localparam int unsigned PAY_BYTES       = 8;   // byte lanes in the payload
  localparam int unsigned HDR_LEN         = 5;   // type, three id chars, length char
  localparam int unsigned ID_LAST_POS     = 3;   // last position of the id field
  localparam int unsigned LEN_POS         = 4;   // position of the length char

  localparam logic [7:0]  CHAR_EXT_DATA   = 8'h54;  // 'T'
  localparam logic [7:0]  CHAR_EXT_REMOTE = 8'h52;  // 'R'
  localparam logic [7:0]  CHAR_STD_DATA   = 8'h74;  // 't'
  localparam logic [7:0]  CHAR_ZERO       = 8'h30;  // '0'
  localparam logic [7:0]  CHAR_NINE       = 8'h39;  // '9'
  localparam logic [7:0]  CHAR_NUL        = 8'h00;
  localparam logic [4:0]  HEX_NONE        = 5'd16;  // decoder code for a non-hex char
  localparam logic [11:0] ID_MAX          = 12'h7FF;
  localparam logic [3:0]  DLC_MAX         = 4'd8;

  // One received character
  typedef struct packed {
    logic [7:0] character;
    logic       chunk_end;
  } char_req_t;

  // One decoded frame
  typedef struct packed {
    logic [10:0] frame_id;
    logic        remote_request;
    logic [3:0]  byte_count;
    logic [63:0] payload;
  } frame_t;

  // Fields collected while a chunk arrives
  typedef struct packed {
    logic [7:0]  type_char;
    logic [11:0] id_acc;
    logic [7:0]  length_char;
    logic [63:0] data_bytes;
  } chunk_fields_t;

  // Hex digit value, or HEX_NONE
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h61 + 8'd10);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

@@ rtl/ahcan_stream_ifs.sv @@
// Valid/ready channel interfaces of the serial-text to CAN frame parser.
// Depends on ahcan_pkg for the payload types.
interface ahcan_char_if import ahcan_pkg::*; ();
  logic      valid;
  logic      ready;
  char_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ahcan_frame_if import ahcan_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ascii_hex_to_can_frame_parser.sv @@
// Serial-text to CAN frame parser: one character per cycle while the skid is empty,
// at most one frame per chunk. At a chunk end the frame is registered into the
// output register, or into the skid when the output is stalled. A two-entry output
// stage (register plus skid) keeps input flowing while a frame waits. Reset (rst_ni,
// async, low) clears the chunk state and empties the output stage.
`include "assert_macros.svh"

module ascii_hex_to_can_frame_parser import ahcan_pkg::*; #(
  parameter int unsigned CHUNK_DEPTH = CHUNK_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ahcan_char_if.sink   char_if,
  ahcan_frame_if.source frame_if
);

  localparam int unsigned PosW = $clog2(CHUNK_DEPTH + 1);

  logic            take;
  logic            in_ready;
  chunk_fields_t   fld;
  logic [PosW-1:0] text_len;

  // Chunk state
  ahcan_chunk_state #(
    .CHUNK_DEPTH(CHUNK_DEPTH)
  ) u_chunk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .last_i     (char_if.data.chunk_end),
    .char_i     (char_if.data.character),
    .fields_o   (fld),
    .text_len_o (text_len)
  );

  // Frame checks and decode at chunk end
  logic [PosW-1:0] plen;
  logic            len_ok, plen_ok, id_ok, type_ok, emit;
  logic [3:0]      digit;
  logic [63:0]     pay_mask;
  frame_t          frame_d;

  assign plen    = (text_len - PosW'(HDR_LEN)) >> 1;
  assign len_ok  = (32'(text_len) >= HDR_LEN);
  assign plen_ok = (32'(plen) <= MAX_PAYLOAD);
  assign id_ok   = (fld.id_acc <= ID_MAX);
  assign type_ok = (fld.type_char != CHAR_EXT_DATA) && (fld.type_char != CHAR_EXT_REMOTE);
  assign emit    = take && char_if.data.chunk_end && len_ok && plen_ok && id_ok && type_ok;

  always_comb begin
    for (int i = 0; i < PAY_BYTES; i++) begin
      pay_mask[i*8 +: 8] = (i < 32'(plen)) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    digit = 4'd0;
    if (fld.length_char >= CHAR_ZERO && fld.length_char <= CHAR_NINE) begin
      digit = 4'(fld.length_char - CHAR_ZERO);
    end
    if (digit > DLC_MAX) digit = DLC_MAX;
  end

  always_comb begin
    frame_d.frame_id = fld.id_acc[10:0];
    if (fld.type_char == CHAR_STD_DATA) begin
      frame_d.remote_request = 1'b0;
      frame_d.byte_count     = 4'(plen);
      frame_d.payload        = fld.data_bytes & pay_mask;
    end else begin
      frame_d.remote_request = 1'b1;
      frame_d.byte_count     = digit;
      frame_d.payload        = '0;
    end
  end

  // Output register with skid stage
  logic   out_valid_q, skid_valid_q, out_free;
  frame_t out_q, skid_q;

  assign in_ready = !skid_valid_q;
  assign take     = char_if.valid && in_ready;
  assign out_free = !out_valid_q || frame_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || emit;
      skid_valid_q <= 1'b0;
    end else if (emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (emit) out_q <= frame_d;
    end else if (emit) begin
      skid_q <= frame_d;
    end
  end

  assign char_if.ready  = in_ready;
  assign frame_if.valid = out_valid_q;
  assign frame_if.data  = out_q;

  // Checks
  `AHCAN_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid full, output empty")
  `AHCAN_ASSERT_NEVER(a_dlc_range, clk_i, rst_ni, out_valid_q && (out_q.byte_count > DLC_MAX), "byte count above 8")
  `AHCAN_ASSERT(a_remote_no_data, clk_i, rst_ni, (out_valid_q && out_q.remote_request) |-> (out_q.payload == '0), "remote frame carries data")
  `AHCAN_ASSERT(a_skid_blocks_input, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(emit && !out_free), "skid loaded without a stalled frame")

endmodule

@@ rtl/ahcan_chunk_state.sv @@
// Running chunk state: position, text length, type, id, length char, data pairs.
// Depends on ahcan_pkg; instantiated by ascii_hex_to_can_frame_parser.
module ahcan_chunk_state import ahcan_pkg::*; #(
  parameter int unsigned CHUNK_DEPTH = CHUNK_DEPTH_DEF,
  localparam int unsigned PosW = $clog2(CHUNK_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,      // request accepted this cycle
  input  logic            last_i,      // accepted char ends the chunk
  input  logic [7:0]      char_i,
  output chunk_fields_t   fields_o,    // fields including this char
  output logic [PosW-1:0] text_len_o   // text length including this char
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] len_q, len_d;
  logic            zero_q, zero_d;
  logic            id_stop_q, id_stop_d;
  logic            pair_stop_q, pair_stop_d;
  chunk_fields_t   fld_q, fld_d;

  logic [4:0]      hex_v;
  logic            is_hex;
  logic [PosW-1:0] pos_off;
  logic [PosW-1:0] byte_idx;
  logic [5:0]      byte_base;
  logic [7:0]      cur_byte;
  logic [7:0]      new_byte;

  assign hex_v     = hex_value(char_i);
  assign is_hex    = (hex_v != HEX_NONE);
  assign pos_off   = pos_q - PosW'(HDR_LEN);
  assign byte_idx  = pos_off >> 1;
  assign byte_base = {byte_idx[2:0], 3'b000};
  assign cur_byte  = fld_q.data_bytes[byte_base +: 8];

  // Data pair digit: first char of a pair restarts the byte
  always_comb begin
    new_byte    = cur_byte;
    pair_stop_d = pair_stop_q;
    if (!pos_off[0]) begin
      if (is_hex) begin
        new_byte    = {4'h0, hex_v[3:0]};
        pair_stop_d = 1'b0;
      end else begin
        new_byte    = 8'h00;
        pair_stop_d = 1'b1;
      end
    end else if (!pair_stop_q && is_hex) begin
      new_byte = {cur_byte[3:0], hex_v[3:0]};
    end
  end

  // Next state for one kept character
  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    zero_d    = zero_q;
    id_stop_d = id_stop_q;
    fld_d     = fld_q;
    if (pos_q < PosW'(CHUNK_DEPTH)) begin
      pos_d = pos_q + PosW'(1);
      if (!zero_q) begin
        if (char_i == CHAR_NUL) zero_d = 1'b1;
        else len_d = len_q + PosW'(1);
      end
      if (pos_q == '0) begin
        fld_d.type_char = char_i;
      end else if (32'(pos_q) <= ID_LAST_POS) begin
        if (!id_stop_q) begin
          if (is_hex) fld_d.id_acc = {fld_q.id_acc[7:0], hex_v[3:0]};
          else id_stop_d = 1'b1;
        end
      end else if (32'(pos_q) == LEN_POS) begin
        fld_d.length_char = char_i;
      end else if (32'(byte_idx) < PAY_BYTES) begin
        fld_d.data_bytes[byte_base +: 8] = new_byte;
      end
    end
  end

  // Pair stop flag only moves on a data position
  logic pair_pos;
  assign pair_pos = (pos_q < PosW'(CHUNK_DEPTH)) && (32'(pos_q) >= HDR_LEN)
                    && (32'(byte_idx) < PAY_BYTES);

  // State registers; a chunk end re-arms reception
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      zero_q      <= 1'b0;
      id_stop_q   <= 1'b0;
      pair_stop_q <= 1'b0;
      fld_q       <= '0;
    end else if (take_i) begin
      if (last_i) begin
        pos_q       <= '0;
        len_q       <= '0;
        zero_q      <= 1'b0;
        id_stop_q   <= 1'b0;
        pair_stop_q <= 1'b0;
        fld_q       <= '0;
      end else begin
        pos_q     <= pos_d;
        len_q     <= len_d;
        zero_q    <= zero_d;
        id_stop_q <= id_stop_d;
        fld_q     <= fld_d;
        if (pair_pos) pair_stop_q <= pair_stop_d;
      end
    end
  end

  assign fields_o   = fld_d;
  assign text_len_o = len_d;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ascii_hex_to_can_frame_parser: feeds serial text
// chunks, predicts each CAN frame in place and checks it. Depends on ahcan_pkg
// and the channel interfaces in ahcan_stream_ifs.sv.
module tb_top import ahcan_pkg::*; ();

  localparam logic [7:0]  CHAR_STD_REMOTE = 8'h72;  // 'r'
  localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0]  CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_F    = 8'h46;
  localparam int unsigned NOT_HEX         = 16;
  localparam int unsigned IDLE_PCT        = 22;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned RANDOM_CHARS    = 500;
  localparam int unsigned BURST_CHUNKS    = 20;
  localparam int unsigned MAX_PRINTED     = 50;

  typedef logic [7:0] chunk_t[$];

  // Running fields of the chunk being received
  typedef struct {
    int unsigned pos;
    int unsigned len;
    bit          nul_seen;
    logic [7:0]  kind;
    logic [11:0] id;
    bit          id_done;
    logic [7:0]  dlc_char;
    logic [63:0] bytes;
    bit          pair_bad;
  } chunk_state_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         char_valid = 1'b0;
  char_req_t    char_data = '0;
  logic         frame_ready = 1'b0;

  chunk_state_t chunk_st;
  frame_t       frames_due[$];
  int unsigned  idle_pct = IDLE_PCT;
  int unsigned  error_count = 0;
  int unsigned  chars_sent = 0;
  int unsigned  frames_seen = 0;
  int unsigned  quiet_cycles = 0;

  ahcan_char_if  char_bus ();
  ahcan_frame_if frame_bus ();

  assign char_bus.valid  = char_valid;
  assign char_bus.data   = char_data;
  assign frame_bus.ready = frame_ready;

  ascii_hex_to_can_frame_parser u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .char_if  (char_bus),
    .frame_if (frame_bus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned hex_digit(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return c - CHAR_LOWER_A + 10;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return c - CHAR_UPPER_A + 10;
    return NOT_HEX;
  endfunction

  // Fold one accepted character into the chunk; at chunk end queue the frame
  function automatic void parse_char(input logic [7:0] c, input logic last);
    int unsigned v;
    int unsigned p;
    int unsigned off;
    int unsigned idx;
    int unsigned plen;
    int unsigned dlc;
    int unsigned i;
    logic [7:0]  cur;
    frame_t      f;
    v = hex_digit(c);
    p = chunk_st.pos;
    if (p < CHUNK_DEPTH_DEF) begin
      chunk_st.pos = p + 1;
      if (!chunk_st.nul_seen) begin
        if (c == CHAR_NUL) chunk_st.nul_seen = 1'b1;
        else chunk_st.len++;
      end
      if (p == 0) begin
        chunk_st.kind = c;
      end else if (p <= ID_LAST_POS) begin
        if (!chunk_st.id_done) begin
          if (v == NOT_HEX) chunk_st.id_done = 1'b1;
          else chunk_st.id = {chunk_st.id[7:0], 4'(v)};
        end
      end else if (p == LEN_POS) begin
        chunk_st.dlc_char = c;
      end else begin
        // hex pairs: a pair restarts on its first char, a bad first char zeroes it
        off = p - HDR_LEN;
        idx = off / 2;
        if (idx < PAY_BYTES) begin
          cur = chunk_st.bytes[idx*8 +: 8];
          if (off % 2 == 0) begin
            if (v == NOT_HEX) begin
              cur = '0;
              chunk_st.pair_bad = 1'b1;
            end else begin
              cur = 8'(v);
              chunk_st.pair_bad = 1'b0;
            end
          end else if (!chunk_st.pair_bad && v != NOT_HEX) begin
            cur = {cur[3:0], 4'(v)};
          end
          chunk_st.bytes[idx*8 +: 8] = cur;
        end
      end
    end
    if (last) begin
      if (chunk_st.kind != CHAR_EXT_DATA && chunk_st.kind != CHAR_EXT_REMOTE &&
          chunk_st.len >= HDR_LEN) begin
        plen = (chunk_st.len - HDR_LEN) / 2;
        if (plen <= MAX_PAYLOAD && chunk_st.id <= ID_MAX) begin
          f.frame_id = chunk_st.id[10:0];
          if (chunk_st.kind == CHAR_STD_DATA) begin
            f.remote_request = 1'b0;
            f.byte_count     = 4'(plen);
            f.payload        = chunk_st.bytes;
            for (i = plen; i < PAY_BYTES; i++) f.payload[i*8 +: 8] = '0;
          end else begin
            // remote: length digit value, capped
            dlc = 0;
            if (chunk_st.dlc_char >= CHAR_ZERO && chunk_st.dlc_char <= CHAR_NINE)
              dlc = chunk_st.dlc_char - CHAR_ZERO;
            if (dlc > DLC_MAX) dlc = DLC_MAX;
            f.remote_request = 1'b1;
            f.byte_count     = 4'(dlc);
            f.payload        = '0;
          end
          frames_due.push_back(f);
        end
      end
      chunk_st = '{default: 0};
    end
  endfunction

  // One character request; valid stays up for a following request
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{character: c, chunk_end: last};
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
    parse_char(c, last);
  endtask

  task automatic send_chunk(input chunk_t q);
    int unsigned i;
    for (i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic append_text(inout chunk_t q, input string s);
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    chunk_t q;
    append_text(q, s);
    send_chunk(q);
  endtask

  // Hold requests until every expected frame is out
  task automatic wait_frames_done();
    char_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return CHAR_ZERO + 8'(v);
    return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v - 10);
  endfunction

  // Occasionally swap in an arbitrary byte
  function automatic logic [7:0] messy(input logic [7:0] c);
    return ($urandom_range(99) < 4) ? 8'($urandom) : c;
  endfunction

  // Mostly well-formed commands with random content, some pure noise
  function automatic chunk_t random_chunk();
    chunk_t      q;
    int unsigned pick;
    int unsigned npairs;
    int unsigned n;
    int unsigned i;
    logic [7:0]  kind;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(1, 30);
      for (i = 0; i < n; i++) q.push_back(8'($urandom));
      return q;
    end
    pick = $urandom_range(99);
    if (pick < 60) kind = CHAR_STD_DATA;
    else if (pick < 85) kind = CHAR_STD_REMOTE;
    else if (pick < 90) kind = $urandom_range(1) ? CHAR_EXT_DATA : CHAR_EXT_REMOTE;
    else kind = 8'($urandom);
    q.push_back(kind);
    // keep most ids within 11 bits
    q.push_back(messy(hex_char(($urandom_range(99) < 80) ? $urandom_range(7)
                                                          : $urandom_range(15))));
    q.push_back(messy(hex_char($urandom_range(15))));
    q.push_back(messy(hex_char($urandom_range(15))));
    q.push_back(messy(CHAR_ZERO + 8'($urandom_range(9))));
    npairs = ($urandom_range(99) < 8) ? $urandom_range(9, 10) : $urandom_range(8);
    for (i = 0; i < npairs; i++) begin
      q.push_back(messy(hex_char($urandom_range(15))));
      q.push_back(messy(hex_char($urandom_range(15))));
    end
    if ($urandom_range(9) == 0) q.push_back(hex_char($urandom_range(15)));
    if ($urandom_range(19) == 0) q.insert($urandom_range(q.size() - 1), CHAR_NUL);
    return q;
  endfunction

  task automatic test_data_frames();
    send_text("t7FF0");
    send_text("t0001A5");
    send_text("t1238FFEEDDCCBBAA9988");
    send_text("t2a3300b1c");
    wait_frames_done();
  endtask

  task automatic test_remote_frames();
    send_text("r1230");
    send_text("r7FF9");
    send_text("x0018");
    send_text("r456G");
    send_text("r12340011");
    wait_frames_done();
  endtask

  task automatic test_dropped_chunks();
    chunk_t q;
    send_text("T12345678");
    send_text("R1234");
    send_text("t12");
    send_text("t8000");
    send_text("t1239001122334455667788");
    q.push_back(8'hFF);
    send_chunk(q);
    q.delete();
    q.push_back(CHAR_NUL);
    send_chunk(q);
    // reception re-arms after drops
    send_text("t0010");
    wait_frames_done();
  endtask

  task automatic test_field_limits();
    chunk_t q;
    send_text("tz120");
    send_text("t1z30");
    send_text("t1233G12x34");
    append_text(q, "t1230A");
    q.push_back(CHAR_NUL);
    append_text(q, "FF");
    send_chunk(q);
    q.delete();
    append_text(q, "t1");
    q.push_back(CHAR_NUL);
    append_text(q, "23456");
    send_chunk(q);
    // past the kept depth, text ended by a zero byte
    q.delete();
    append_text(q, "t7FF8FFEEDDCCBBAA9988");
    q.push_back(CHAR_NUL);
    append_text(q, "0123456789");
    send_chunk(q);
    send_text("t00000000000000000000000000000");
    wait_frames_done();
  endtask

  task automatic test_back_to_back();
    int unsigned i;
    idle_pct = 0;
    for (i = 0; i < BURST_CHUNKS; i++) send_chunk(random_chunk());
    wait_frames_done();
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      send_chunk(random_chunk());
      if ($urandom_range(19) == 0) wait_frames_done();
    end
    wait_frames_done();
  endtask

  // Frame checker and random backpressure
  always @(posedge clk) begin
    frame_t exp_f;
    frame_t got_f;
    if (rst_n) begin
      if (frame_bus.valid && frame_ready) begin
        got_f = frame_bus.data;
        if (frames_due.size() == 0) begin
          report_error($sformatf("unexpected frame id %h", got_f.frame_id));
        end else begin
          exp_f = frames_due.pop_front();
          if (got_f.frame_id !== exp_f.frame_id)
            report_error($sformatf("frame %0d frame_id %h, want %h", frames_seen,
                                   got_f.frame_id, exp_f.frame_id));
          if (got_f.remote_request !== exp_f.remote_request)
            report_error($sformatf("frame %0d remote_request %b, want %b", frames_seen,
                                   got_f.remote_request, exp_f.remote_request));
          if (got_f.byte_count !== exp_f.byte_count)
            report_error($sformatf("frame %0d byte_count %0d, want %0d", frames_seen,
                                   got_f.byte_count, exp_f.byte_count));
          if (got_f.payload !== exp_f.payload)
            report_error($sformatf("frame %0d payload %h, want %h", frames_seen,
                                   got_f.payload, exp_f.payload));
        end
        frames_seen++;
      end
      frame_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no request or frame moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((char_valid && char_bus.ready) || (frame_bus.valid && frame_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    chunk_st = '{default: 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_data_frames();
    test_remote_frames();
    test_dropped_chunks();
    test_field_limits();
    test_back_to_back();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frames_due.size() != 0)
      report_error($sformatf("%0d frames never arrived", frames_due.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ahcan_pkg.sv
rtl/ahcan_stream_ifs.sv
rtl/ahcan_chunk_state.sv
rtl/ascii_hex_to_can_frame_parser.sv
tb/tb_top.sv
